FILE: design/pstg_pkg.sv
// ----------------------------------------------------------------------------
// pstg_pkg: shared definitions of the polar two-axis step generator
// Field widths, command and register codes, and the status word of the
// serial arithmetic units.
// ----------------------------------------------------------------------------
`default_nettype none

package pstg_pkg;

   localparam int DATA_W      = 32;   // Q16.16 words
   localparam int FRAC_W      = 16;
   localparam int CMD_W       = 2;
   localparam int CSR_INDEX_W = 3;
   localparam int OUT_COUNT_W = 24;   // reported width of the tick counts
   localparam int COUNT_BITS  = 24;   // saturation width of the tick counts

   // serial multiplier: 48-bit multiplicand, 32-bit multiplier
   localparam int MUL_A_W = 48;
   localparam int MUL_B_W = DATA_W;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   typedef logic [COUNT_BITS-1:0] count_type;

   localparam logic [CMD_W-1:0] CMD_LOAD_MOVE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ANGLE_TICK  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_RADIUS_TICK = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] REG_RADIUS_TICKS_PER_MM    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ANGLE_TICKS_PER_RAD    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_COUPLING_MM_PER_RAD    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MM_PER_RADIUS_TICK     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_RAD_PER_ANGLE_TICK     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_COUPLING_MM_PER_ATICK  = 3'd5;

   // status of a multi-cycle arithmetic unit
   typedef struct packed {
      logic busy;   // iterating
      logic done;   // one-cycle pulse, result valid
   } unit_status_type;

endpackage

`default_nettype wire

FILE: design/pstg_if.sv
// ----------------------------------------------------------------------------
// pstg channels: request, response and register-write channels
// Each carries valid, ready and its word; a word moves when both are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface pstg_req_if;
   import pstg_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic signed [DATA_W-1:0] delta_radius;
   logic signed [DATA_W-1:0] delta_angle;
   logic [DATA_W-1:0]        move_time;
   logic                     motion_enabled;

   modport source (output valid, command, delta_radius, delta_angle, move_time,
                   motion_enabled, input ready);
   modport sink   (input valid, command, delta_radius, delta_angle, move_time,
                   motion_enabled, output ready);
endinterface

interface pstg_rsp_if;
   import pstg_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OUT_COUNT_W-1:0]   radius_remaining;
   logic [OUT_COUNT_W-1:0]   angle_remaining;
   logic                     radius_direction;
   logic                     angle_direction;
   logic [DATA_W-1:0]        radius_period;
   logic [DATA_W-1:0]        angle_period;
   logic                     radius_step_level;
   logic                     angle_step_level;
   logic signed [DATA_W-1:0] position_radius;
   logic signed [DATA_W-1:0] position_angle;

   modport source (output valid, radius_remaining, angle_remaining, radius_direction,
                   angle_direction, radius_period, angle_period, radius_step_level,
                   angle_step_level, position_radius, position_angle, input ready);
   modport sink   (input valid, radius_remaining, angle_remaining, radius_direction,
                   angle_direction, radius_period, angle_period, radius_step_level,
                   angle_step_level, position_radius, position_angle, output ready);
endinterface

interface pstg_csr_if;
   import pstg_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [DATA_W-1:0]      data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/pstg_mul.sv
// ----------------------------------------------------------------------------
// pstg_mul: serial shift-add multiplier
// Takes one multiplier bit per cycle; the full product is ready when done
// pulses and holds until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module pstg_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [pstg_pkg::MUL_A_W-1:0]   multiplicand,
   input  logic [pstg_pkg::MUL_B_W-1:0]   multiplier,
   output pstg_pkg::unit_status_type      status,
   output logic [pstg_pkg::MUL_P_W-1:0]   product
);
   import pstg_pkg::*;

   localparam int CNT_W = $clog2(MUL_B_W);

   logic [MUL_A_W-1:0] mcand_ff;
   logic [MUL_B_W-1:0] mplier_ff;
   logic [MUL_P_W-1:0] acc_ff;
   logic [MUL_P_W-1:0] acc_in;
   logic [MUL_A_W:0]   part_sum;
   logic [CNT_W-1:0]   cnt_ff;
   logic               busy_ff;
   logic               done_ff;
   logic               last_step;

   // add the multiplicand into the high half, then shift right one place
   always_comb begin
      part_sum = {1'b0, acc_ff[MUL_P_W-1:MUL_B_W]}
               + (mplier_ff[0] ? {1'b0, mcand_ff} : {(MUL_A_W+1){1'b0}});
      acc_in   = {part_sum, acc_ff[MUL_B_W-1:1]};
   end

   assign last_step = busy_ff && (cnt_ff == CNT_W'(MUL_B_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= last_step;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (last_step) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff  <= multiplicand;
         mplier_ff <= multiplier;
         acc_ff    <= '0;
      end else if (busy_ff) begin
         mplier_ff <= {1'b0, mplier_ff[MUL_B_W-1:1]};
         acc_ff    <= acc_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign product     = acc_ff;

endmodule

`default_nettype wire

FILE: design/pstg_div.sv
// ----------------------------------------------------------------------------
// pstg_div: serial restoring divider
// One quotient bit per cycle; a zero divisor yields an all-ones quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module pstg_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pstg_pkg::DATA_W-1:0]   dividend,
   input  pstg_pkg::count_type           divisor,
   output pstg_pkg::unit_status_type     status,
   output logic [pstg_pkg::DATA_W-1:0]   quotient
);
   import pstg_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   logic [DATA_W-1:0]   quo_ff;      // dividend shifts out, quotient shifts in
   count_type           rem_ff;
   count_type           rem_in;
   count_type           den_ff;
   logic [COUNT_BITS:0] rem_shift;
   logic [COUNT_BITS:0] rem_diff;
   logic                fits;
   logic [CNT_W-1:0]    cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic                last_step;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DATA_W-1]};
      rem_diff  = rem_shift - {1'b0, den_ff};
      fits      = rem_shift >= {1'b0, den_ff};
      rem_in    = fits ? rem_diff[COUNT_BITS-1:0] : rem_shift[COUNT_BITS-1:0];
   end

   assign last_step = busy_ff && (cnt_ff == CNT_W'(DATA_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= last_step;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (last_step) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DATA_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

`default_nettype wire

FILE: design/polar_two_axis_step_generator.sv
// ----------------------------------------------------------------------------
// polar_two_axis_step_generator: radius and rotation stepper engine
// Turns move loads into tick counts, directions and tick periods, and
// timer ticks into step levels, counts and tracked positions.
// ----------------------------------------------------------------------------
//
//   channel  dir  word
//   -------  ---  --------------------------------------------------------
//   csr_ch   in   register index and data, always ready
//   req_ch   in   command, deltas, move time, motion enable
//   rsp_ch   out  counts, directions, periods, step levels, positions
//
// A load move runs four products on the shared shift-add multiplier, then a
// compare and a sum state, then two quotients on the restoring divider. A
// timer tick or an unused command goes through the tick state to the output
// state. Reset is synchronous and clears the registers, axis state and both
// handshakes. The result register holds while rsp_ch stalls; the next request
// word is taken once the result is parked.
// ----------------------------------------------------------------------------
`default_nettype none

module polar_two_axis_step_generator (
   input  logic       clock,
   input  logic       reset,
   pstg_csr_if.sink   csr_ch,
   pstg_req_if.sink   req_ch,
   pstg_rsp_if.source rsp_ch
);
   import pstg_pkg::*;

   // sequencer states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_MUL_RT   = 4'd1;   // radius ticks
   localparam logic [3:0] S_MUL_CLEN = 4'd2;   // coupling length
   localparam logic [3:0] S_MUL_CT   = 4'd3;   // coupling ticks
   localparam logic [3:0] S_MUL_AT   = 4'd4;   // angle ticks
   localparam logic [3:0] S_CMP      = 4'd5;
   localparam logic [3:0] S_SUM      = 4'd6;
   localparam logic [3:0] S_DIV_R    = 4'd7;   // radius period
   localparam logic [3:0] S_DIV_A    = 4'd8;   // angle period
   localparam logic [3:0] S_TICK     = 4'd9;
   localparam logic [3:0] S_OUT      = 4'd10;

   localparam int PAD_W = MUL_A_W - DATA_W;

   // clamp a tick count to the count width
   function automatic count_type sat_count(input logic [MUL_A_W:0] v);
      if (v[MUL_A_W:COUNT_BITS] != '0) begin
         return '1;
      end
      return v[COUNT_BITS-1:0];
   endfunction

   // low bits of a count as reported on the result word
   function automatic logic [OUT_COUNT_W-1:0] out_count(input count_type c);
      logic [COUNT_BITS+OUT_COUNT_W-1:0] wide;
      wide = {{OUT_COUNT_W{1'b0}}, c};
      return wide[OUT_COUNT_W-1:0];
   endfunction

   logic [3:0] state_ff, state_in;

   // configuration
   logic [DATA_W-1:0] rtpm_ff, atpr_ff, cmpr_ff, mprt_ff, rpat_ff, cmpat_ff;

   // axis state
   count_type         radius_count_ff, angle_count_ff;
   logic              radius_dir_ff, angle_dir_ff;
   logic              radius_step_ff, angle_step_ff;
   logic [DATA_W-1:0] radius_pos_ff, angle_pos_ff;

   // held request and intermediate results
   logic [CMD_W-1:0]   cmd_ff;
   logic               en_ff, dr_neg_ff, da_pos_ff;
   logic [DATA_W-1:0]  ma_ff, tm_ff;
   logic [MUL_A_W-1:0] rt_ff, ct_ff, at_ff;
   logic               gt_ff;
   logic [DATA_W-1:0]  rper_ff, aper_ff;

   // result register
   logic                   rsp_valid_ff;
   logic [OUT_COUNT_W-1:0] rsp_rrem_ff, rsp_arem_ff;
   logic                   rsp_rdir_ff, rsp_adir_ff, rsp_rstep_ff, rsp_astep_ff;
   logic [DATA_W-1:0]      rsp_rper_ff, rsp_aper_ff, rsp_rpos_ff, rsp_apos_ff;

   // arithmetic units
   logic               mul_start;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_prod;
   unit_status_type    mul_stat;
   logic               div_start;
   logic [DATA_W-1:0]  div_dividend;
   count_type          div_divisor;
   logic [DATA_W-1:0]  div_quo;
   unit_status_type    div_stat;

   logic               req_take, rsp_load, is_load;
   logic [DATA_W-1:0]  dr_raw, da_raw, mag_r, mag_a;
   logic [MUL_A_W-1:0] tick_rnd, clen_rnd;
   logic               agree, take_rt, radius_dir_in;
   logic [MUL_A_W-1:0] op_x, op_y;
   logic [MUL_A_W:0]   rc_sum;
   count_type          radius_count_in;
   logic               angle_live, radius_live;
   logic [DATA_W-1:0]  angle_pos_in, radius_pos_in, rad_addend;
   logic               rad_sub;

   assign csr_ch.ready = 1'b1;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign is_load      = (req_ch.command == CMD_LOAD_MOVE);
   assign rsp_load     = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ch.ready);

   // magnitudes of the deltas; the most negative value stays 2^31
   always_comb begin
      dr_raw = req_ch.delta_radius;
      da_raw = req_ch.delta_angle;
      mag_r  = dr_raw[DATA_W-1] ? (~dr_raw + DATA_W'(1)) : dr_raw;
      mag_a  = da_raw[DATA_W-1] ? (~da_raw + DATA_W'(1)) : da_raw;
   end

   // round half up: keep the upper part and add the first dropped bit
   always_comb begin
      tick_rnd = mul_prod[MUL_P_W-1:DATA_W] + MUL_A_W'(mul_prod[DATA_W-1]);
      clen_rnd = mul_prod[FRAC_W+MUL_A_W-1:FRAC_W] + MUL_A_W'(mul_prod[FRAC_W-1]);
   end

   // chain the four products on the one multiplier
   always_comb begin
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_take && is_load) begin
               mul_start = 1'b1;
               mul_a     = {{PAD_W{1'b0}}, mag_r};
               mul_b     = rtpm_ff;
            end
         end
         S_MUL_RT: begin
            if (mul_stat.done) begin
               mul_start = 1'b1;
               mul_a     = {{PAD_W{1'b0}}, ma_ff};
               mul_b     = cmpr_ff;
            end
         end
         S_MUL_CLEN: begin
            if (mul_stat.done) begin
               mul_start = 1'b1;
               mul_a     = clen_rnd;
               mul_b     = rtpm_ff;
            end
         end
         S_MUL_CT: begin
            if (mul_stat.done) begin
               mul_start = 1'b1;
               mul_a     = {{PAD_W{1'b0}}, ma_ff};
               mul_b     = atpr_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // combine radius and coupling ticks: add when the directions agree,
   // otherwise take the difference and flip direction when it is not positive
   always_comb begin
      agree           = (da_pos_ff != dr_neg_ff);
      take_rt         = agree || gt_ff;
      op_x            = take_rt ? rt_ff : ct_ff;
      op_y            = take_rt ? ct_ff : rt_ff;
      rc_sum          = agree ? ({1'b0, op_x} + {1'b0, op_y})
                              : ({1'b0, op_x} - {1'b0, op_y});
      radius_dir_in   = take_rt ? dr_neg_ff : !dr_neg_ff;
      radius_count_in = sat_count(rc_sum);
   end

   // period divides: radius first, then angle
   always_comb begin
      div_start    = 1'b0;
      div_dividend = tm_ff;
      div_divisor  = radius_count_in;
      case (state_ff)
         S_SUM: begin
            div_start = 1'b1;
         end
         S_DIV_R: begin
            div_divisor = angle_count_ff;
            div_start   = div_stat.done;
         end
         default: begin
         end
      endcase
   end

   // timer tick datapath; the rotation also shifts the radius
   always_comb begin
      angle_live    = en_ff && (angle_count_ff != '0);
      radius_live   = en_ff && (radius_count_ff != '0);
      angle_pos_in  = angle_dir_ff ? (angle_pos_ff - rpat_ff) : (angle_pos_ff + rpat_ff);
      rad_addend    = (cmd_ff == CMD_ANGLE_TICK) ? cmpat_ff : mprt_ff;
      rad_sub       = (cmd_ff == CMD_ANGLE_TICK) ? !angle_dir_ff : radius_dir_ff;
      radius_pos_in = rad_sub ? (radius_pos_ff - rad_addend) : (radius_pos_ff + rad_addend);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = is_load ? S_MUL_RT : S_TICK;
            end
         end
         S_MUL_RT:   if (mul_stat.done) state_in = S_MUL_CLEN;
         S_MUL_CLEN: if (mul_stat.done) state_in = S_MUL_CT;
         S_MUL_CT:   if (mul_stat.done) state_in = S_MUL_AT;
         S_MUL_AT:   if (mul_stat.done) state_in = S_CMP;
         S_CMP:      state_in = S_SUM;
         S_SUM:      state_in = S_DIV_R;
         S_DIV_R:    if (div_stat.done) state_in = S_DIV_A;
         S_DIV_A:    if (div_stat.done) state_in = S_OUT;
         S_TICK:     state_in = S_OUT;
         S_OUT:      if (rsp_load) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // control, configuration and axis state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         rtpm_ff         <= '0;
         atpr_ff         <= '0;
         cmpr_ff         <= '0;
         mprt_ff         <= '0;
         rpat_ff         <= '0;
         cmpat_ff        <= '0;
         radius_count_ff <= '0;
         angle_count_ff  <= '0;
         radius_dir_ff   <= 1'b0;
         angle_dir_ff    <= 1'b0;
         radius_step_ff  <= 1'b0;
         angle_step_ff   <= 1'b0;
         radius_pos_ff   <= '0;
         angle_pos_ff    <= '0;
      end else begin
         state_ff <= state_in;

         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               REG_RADIUS_TICKS_PER_MM:   rtpm_ff  <= csr_ch.data;
               REG_ANGLE_TICKS_PER_RAD:   atpr_ff  <= csr_ch.data;
               REG_COUPLING_MM_PER_RAD:   cmpr_ff  <= csr_ch.data;
               REG_MM_PER_RADIUS_TICK:    mprt_ff  <= csr_ch.data;
               REG_RAD_PER_ANGLE_TICK:    rpat_ff  <= csr_ch.data;
               REG_COUPLING_MM_PER_ATICK: cmpat_ff <= csr_ch.data;
               default: begin
               end
            endcase
         end

         if (state_ff == S_SUM) begin
            radius_count_ff <= radius_count_in;
            radius_dir_ff   <= radius_dir_in;
            angle_count_ff  <= sat_count({1'b0, at_ff});
            angle_dir_ff    <= !da_pos_ff;
         end

         if (state_ff == S_TICK) begin
            case (cmd_ff)
               CMD_ANGLE_TICK: begin
                  if (angle_live) begin
                     if (!angle_step_ff) begin
                        angle_step_ff <= 1'b1;
                        angle_pos_ff  <= angle_pos_in;
                        radius_pos_ff <= radius_pos_in;
                     end else begin
                        angle_step_ff  <= 1'b0;
                        angle_count_ff <= angle_count_ff - COUNT_BITS'(1);
                     end
                  end
               end
               CMD_RADIUS_TICK: begin
                  if (radius_live) begin
                     if (!radius_step_ff) begin
                        radius_step_ff <= 1'b1;
                        radius_pos_ff  <= radius_pos_in;
                     end else begin
                        radius_step_ff  <= 1'b0;
                        radius_count_ff <= radius_count_ff - COUNT_BITS'(1);
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // held request, intermediate products and the result word
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff    <= req_ch.command;
         en_ff     <= req_ch.motion_enabled;
         dr_neg_ff <= dr_raw[DATA_W-1];
         da_pos_ff <= !da_raw[DATA_W-1] && (da_raw != '0);
         ma_ff     <= mag_a;
         tm_ff     <= req_ch.move_time;
         if (!is_load) begin
            rper_ff <= '0;
            aper_ff <= '0;
         end
      end
      if (mul_stat.done) begin
         case (state_ff)
            S_MUL_RT: rt_ff <= tick_rnd;
            S_MUL_CT: ct_ff <= tick_rnd;
            S_MUL_AT: at_ff <= tick_rnd;
            default: begin
            end
         endcase
      end
      if (state_ff == S_CMP) begin
         gt_ff <= rt_ff > ct_ff;
      end
      if (div_stat.done) begin
         case (state_ff)
            S_DIV_R: rper_ff <= div_quo;
            S_DIV_A: aper_ff <= div_quo;
            default: begin
            end
         endcase
      end
      if (rsp_load) begin
         rsp_rrem_ff  <= out_count(radius_count_ff);
         rsp_arem_ff  <= out_count(angle_count_ff);
         rsp_rdir_ff  <= radius_dir_ff;
         rsp_adir_ff  <= angle_dir_ff;
         rsp_rper_ff  <= rper_ff;
         rsp_aper_ff  <= aper_ff;
         rsp_rstep_ff <= radius_step_ff;
         rsp_astep_ff <= angle_step_ff;
         rsp_rpos_ff  <= radius_pos_ff;
         rsp_apos_ff  <= angle_pos_ff;
      end
   end

   pstg_mul u_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (mul_a),
      .multiplier   (mul_b),
      .status       (mul_stat),
      .product      (mul_prod)
   );

   pstg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_stat),
      .quotient (div_quo)
   );

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.radius_remaining  = rsp_rrem_ff;
   assign rsp_ch.angle_remaining   = rsp_arem_ff;
   assign rsp_ch.radius_direction  = rsp_rdir_ff;
   assign rsp_ch.angle_direction   = rsp_adir_ff;
   assign rsp_ch.radius_period     = rsp_rper_ff;
   assign rsp_ch.angle_period      = rsp_aper_ff;
   assign rsp_ch.radius_step_level = rsp_rstep_ff;
   assign rsp_ch.angle_step_level  = rsp_astep_ff;
   assign rsp_ch.position_radius   = rsp_rpos_ff;
   assign rsp_ch.position_angle    = rsp_apos_ff;

`ifndef SYNTHESIS
   a_mul_start_free: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_stat.busy)
      else $error("multiplier restarted while busy");

   a_div_start_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && rsp_valid_ff && !rsp_ch.ready) |=> (state_ff == S_OUT))
      else $error("result dropped while response stalled");

   a_radius_rise_live: assert property (@(posedge clock) disable iff (reset)
      $rose(radius_step_ff) |-> ($past(radius_count_ff) != '0))
      else $error("radius step raised with zero count");

   a_angle_rise_live: assert property (@(posedge clock) disable iff (reset)
      $rose(angle_step_ff) |-> ($past(angle_count_ff) != '0))
      else $error("angle step raised with zero count");
`endif

endmodule

`default_nettype wire
